### rtl/fpp_pkg.sv
// shared types and constants for the framed packet parser
package fpp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1
  } cfg_reg_t;

  localparam byte_t START_MARKER_RST = 8'h24;
  localparam byte_t END_MARKER_RST   = 8'h23;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDRESS = 3'd1,
    PH_COMMAND = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_HSUM    = 3'd4,
    PH_DATA    = 3'd5,
    PH_CRC     = 3'd6,
    PH_END     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_DROPPED  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    byte_t payload_byte;
    byte_t byte_index;
    byte_t address;
    byte_t command;
    byte_t payload_length;
    byte_t hdr_csum;
    byte_t crc_byte;
  } result_t;

endpackage

### rtl/fpp_parser.sv
// frame state machine: header capture, payload indexing, close and restart reports
module fpp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  fpp_pkg::byte_t   rx_byte,
  input  fpp_pkg::byte_t   start_marker,
  input  fpp_pkg::byte_t   end_marker,
  output logic             res_valid,
  output fpp_pkg::result_t res
);
  import fpp_pkg::*;

  phase_t phase_r, phase_nxt;
  byte_t  address_r, address_nxt;
  byte_t  command_r, command_nxt;
  byte_t  length_r, length_nxt;
  byte_t  hsum_r, hsum_nxt;
  byte_t  crc_r, crc_nxt;
  byte_t  count_r, count_nxt;
  logic   emit;

  always_comb begin
    phase_nxt   = phase_r;
    address_nxt = address_r;
    command_nxt = command_r;
    length_nxt  = length_r;
    hsum_nxt    = hsum_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    emit        = 1'b0;
    res         = '0;
    res.address         = address_r;
    res.command         = command_r;
    res.payload_length  = length_r;
    res.hdr_csum        = hsum_r;
    res.crc_byte        = crc_r;

    if (rx_byte == start_marker) begin
      // restart: report what was held so far, then clear
      emit        = (phase_r != PH_IDLE);
      res.kind    = KIND_DROPPED;
      address_nxt = '0;
      command_nxt = '0;
      length_nxt  = '0;
      hsum_nxt    = '0;
      crc_nxt     = '0;
      count_nxt   = '0;
      phase_nxt   = PH_ADDRESS;
    end else begin
      case (phase_r)
        PH_ADDRESS: begin
          address_nxt = rx_byte;
          phase_nxt   = PH_COMMAND;
        end
        PH_COMMAND: begin
          command_nxt = rx_byte;
          phase_nxt   = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_nxt = rx_byte;
          phase_nxt  = PH_HSUM;
        end
        PH_HSUM: begin
          hsum_nxt  = rx_byte;
          count_nxt = '0;
          phase_nxt = (length_r == '0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          emit             = 1'b1;
          res              = '0;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
          res.byte_index   = count_r;
          count_nxt        = count_r + 8'd1;
          if (count_nxt == length_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          crc_nxt   = rx_byte;
          phase_nxt = PH_END;
        end
        PH_END: begin
          emit      = 1'b1;
          res.kind  = (rx_byte == end_marker) ? KIND_ACCEPTED : KIND_DROPPED;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  assign res_valid = item_valid & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      address_r <= '0;
      command_r <= '0;
      length_r  <= '0;
      hsum_r    <= '0;
      crc_r     <= '0;
      count_r   <= '0;
    end else if (item_valid) begin
      phase_r   <= phase_nxt;
      address_r <= address_nxt;
      command_r <= command_nxt;
      length_r  <= length_nxt;
      hsum_r    <= hsum_nxt;
      crc_r     <= crc_nxt;
      count_r   <= count_nxt;
    end
  end

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && rx_byte == start_marker |=> phase_r == PH_ADDRESS)
    else $error("start marker did not restart framing");

  a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && phase_r == PH_DATA && rx_byte != start_marker
      |-> res_valid && res.kind == KIND_PAYLOAD)
    else $error("payload word without payload result");

  a_data_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> length_r != '0)
    else $error("data phase entered with zero length");

endmodule

### rtl/fpp_out_buf.sv
// result register with a skid stage so input keeps flowing through a one-word output stall
module fpp_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fpp_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fpp_pkg::result_t out_data
);
  import fpp_pkg::*;

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    pop;

  assign pop        = out_valid_r & out_ready;
  assign push_ready = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while output is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    push && out_valid_r && !out_ready |=> skid_valid_r)
    else $error("stalled word not parked in skid");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> out_valid_r && !skid_valid_r && out_data_r == $past(skid_data_r))
    else $error("skid word not moved to output");

endmodule

### rtl/framed_packet_parser.sv
// top level: config registers, frame parser and result buffer
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid / in_ready   | in_rx_byte
//  out     | source    | out_valid / out_ready | out_kind .. out_crc_byte
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one byte per cycle while in_ready is high; each byte is parsed in the cycle it
// is taken and its result (if any) shows on out_* the next cycle unless the output
// is stalled. a skid stage behind the result register keeps in_ready high through a
// one-word output stall; in_ready drops only while the skid stage is full.
// rst_n is synchronous: idle phase, held fields cleared, markers to '$' and '#'.
// cfg_ready is always high.
module framed_packet_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fpp_pkg::byte_t           in_rx_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fpp_pkg::kind_t           out_kind,
  output fpp_pkg::byte_t           out_payload_byte,
  output fpp_pkg::byte_t           out_byte_index,
  output fpp_pkg::byte_t           out_address,
  output fpp_pkg::byte_t           out_command,
  output fpp_pkg::byte_t           out_payload_length,
  output fpp_pkg::byte_t           out_hdr_csum,
  output fpp_pkg::byte_t           out_crc_byte,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  fpp_pkg::byte_t           cfg_data
);
  import fpp_pkg::*;

  byte_t   start_marker_r;
  byte_t   end_marker_r;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_MARKER: start_marker_r <= cfg_data;
        REG_END_MARKER:   end_marker_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  fpp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (in_accept),
    .rx_byte      (in_rx_byte),
    .start_marker (start_marker_r),
    .end_marker   (end_marker_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  fpp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_kind            = out_data.kind;
  assign out_payload_byte    = out_data.payload_byte;
  assign out_byte_index      = out_data.byte_index;
  assign out_address         = out_data.address;
  assign out_command         = out_data.command;
  assign out_payload_length  = out_data.payload_length;
  assign out_hdr_csum        = out_data.hdr_csum;
  assign out_crc_byte        = out_data.crc_byte;

endmodule

### test/framed_packet_parser_checker.sv
// checker for the framed packet parser: tracks the frame state and compares each result word
module framed_packet_parser_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fpp_pkg::byte_t                  in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fpp_pkg::kind_t                  out_kind,
  input  fpp_pkg::byte_t                  out_payload_byte,
  input  fpp_pkg::byte_t                  out_byte_index,
  input  fpp_pkg::byte_t                  out_address,
  input  fpp_pkg::byte_t                  out_command,
  input  fpp_pkg::byte_t                  out_payload_length,
  input  fpp_pkg::byte_t                  out_hdr_csum,
  input  fpp_pkg::byte_t                  out_crc_byte,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  fpp_pkg::byte_t                  cfg_data,
  output int                              mismatches,
  output int                              words_due
);
  import fpp_pkg::*;

  result_t due_words[$];

  byte_t  start_mk = START_MARKER_RST;
  byte_t  end_mk   = END_MARKER_RST;
  phase_t ph       = PH_IDLE;
  byte_t  h_addr   = '0;
  byte_t  h_cmd    = '0;
  byte_t  h_len    = '0;
  byte_t  h_hsum   = '0;
  byte_t  h_crc    = '0;
  byte_t  n_seen   = '0;

  function automatic result_t packet_word(input kind_t k);
    result_t w;
    w = '0;
    w.kind            = k;
    w.address         = h_addr;
    w.command         = h_cmd;
    w.payload_length  = h_len;
    w.hdr_csum        = h_hsum;
    w.crc_byte        = h_crc;
    return w;
  endfunction

  task automatic clear_fields();
    h_addr = '0;
    h_cmd  = '0;
    h_len  = '0;
    h_hsum = '0;
    h_crc  = '0;
    n_seen = '0;
  endtask

  // advance the frame state by one received byte, queue the word it causes
  task automatic deframe_byte(input byte_t b);
    result_t w;
    w = '0;
    if (b == start_mk) begin
      // start marker wins over everything, even an equal end marker
      if (ph != PH_IDLE) due_words.push_back(packet_word(KIND_DROPPED));
      clear_fields();
      ph = PH_ADDRESS;
    end else begin
      case (ph)
        PH_ADDRESS: begin
          h_addr = b;
          ph = PH_COMMAND;
        end
        PH_COMMAND: begin
          h_cmd = b;
          ph = PH_LENGTH;
        end
        PH_LENGTH: begin
          h_len = b;
          ph = PH_HSUM;
        end
        PH_HSUM: begin
          h_hsum = b;
          n_seen = '0;
          if (h_len == 8'd0) ph = PH_CRC;
          else ph = PH_DATA;
        end
        PH_DATA: begin
          w.kind         = KIND_PAYLOAD;
          w.payload_byte = b;
          w.byte_index   = n_seen;
          due_words.push_back(w);
          n_seen = n_seen + 8'd1;
          if (n_seen == h_len) ph = PH_CRC;
        end
        PH_CRC: begin
          h_crc = b;
          ph = PH_END;
        end
        PH_END: begin
          if (b == end_mk) due_words.push_back(packet_word(KIND_ACCEPTED));
          else due_words.push_back(packet_word(KIND_DROPPED));
          ph = PH_IDLE;
        end
        default: ph = PH_IDLE;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t w;
    if (!rst_n) begin
      due_words.delete();
      start_mk = START_MARKER_RST;
      end_mk   = END_MARKER_RST;
      ph       = PH_IDLE;
      clear_fields();
      mismatches = 0;
    end else begin
      // a byte taken at this edge cannot show its word before the next one
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $error("result word with none expected: kind %0d", out_kind);
          mismatches++;
        end else begin
          w = due_words.pop_front();
          check_field("kind", 8'(w.kind), 8'(out_kind));
          check_field("payload_byte", w.payload_byte, out_payload_byte);
          check_field("byte_index", w.byte_index, out_byte_index);
          check_field("address", w.address, out_address);
          check_field("command", w.command, out_command);
          check_field("payload_length", w.payload_length, out_payload_length);
          check_field("hdr_csum", w.hdr_csum, out_hdr_csum);
          check_field("crc_byte", w.crc_byte, out_crc_byte);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START_MARKER) start_mk = cfg_data;
        else if (cfg_index == REG_END_MARKER) end_mk = cfg_data;
      end
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
    end
    words_due = due_words.size();
  end

endmodule

### test/framed_packet_parser_tb.sv
// testbench top for the framed packet parser: stimulus, flow control and verdict
module framed_packet_parser_tb;
  import fpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 280;
  localparam int unsigned NUM_PHASES  = 6;

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_valid   = 1'b0;
  logic     in_ready;
  byte_t    in_rx_byte = '0;
  logic     out_valid;
  logic     out_ready  = 1'b0;
  kind_t    out_kind;
  byte_t    out_payload_byte;
  byte_t    out_byte_index;
  byte_t    out_address;
  byte_t    out_command;
  byte_t    out_payload_length;
  byte_t    out_hdr_csum;
  byte_t    out_crc_byte;
  logic     cfg_valid  = 1'b0;
  logic     cfg_ready;
  cfg_reg_t cfg_index  = REG_START_MARKER;
  byte_t    cfg_data   = '0;

  int          mismatches;
  int          words_due;
  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  int unsigned sent       = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  byte_t       smk        = START_MARKER_RST;
  byte_t       emk        = END_MARKER_RST;

  // idle noise, a good frame with extreme fields, a zero-length frame with a bad
  // end byte, then a restart in mid-header
  byte_t opening [23] = '{
    8'h00, 8'hFF,
    8'h24, 8'hFF, 8'h00, 8'h03, 8'hAA, 8'h00, 8'h23, 8'hFF, 8'h55, 8'h23,
    8'h24, 8'h00, 8'hFF, 8'h00, 8'h11, 8'h22, 8'h00,
    8'h24, 8'h12, 8'h34, 8'h24
  };

  framed_packet_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_byte_index      (out_byte_index),
    .out_address         (out_address),
    .out_command         (out_command),
    .out_payload_length  (out_payload_length),
    .out_hdr_csum        (out_hdr_csum),
    .out_crc_byte        (out_crc_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  framed_packet_parser_checker frame_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_byte_index      (out_byte_index),
    .out_address         (out_address),
    .out_command         (out_command),
    .out_payload_length  (out_payload_length),
    .out_hdr_csum        (out_hdr_csum),
    .out_crc_byte        (out_crc_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatches          (mismatches),
    .words_due           (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: switches between free flow, random stalls and long stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= (cycles % 8 == 0);
    endcase
  end

  // hand one word to the block; valid stays up across back-to-back words
  task automatic send_byte(input byte_t b);
    in_rx_byte <= b;
    if (!in_valid) in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // mostly avoids the start marker so frames get past the header
  function automatic byte_t field_byte();
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    if (b == smk && $urandom_range(0, 19) != 0) b = b + 8'd1;
    return b;
  endfunction

  task automatic send_frame(input bit cut_short);
    byte_t       fr[$];
    byte_t       len;
    int unsigned r;
    int unsigned keep;
    r = $urandom_range(0, 99);
    if (r < 10) len = 8'd0;
    else if (r < 94) len = byte_t'($urandom_range(1, 8));
    else if (r < 98) len = byte_t'($urandom_range(9, 40));
    else len = 8'd255;
    if (len == smk) len = len ^ 8'd1;
    fr.push_back(smk);
    fr.push_back(field_byte());
    fr.push_back(field_byte());
    fr.push_back(len);
    fr.push_back(field_byte());
    repeat (len) fr.push_back(field_byte());
    fr.push_back(field_byte());
    if ($urandom_range(0, 9) != 0) fr.push_back(emk);
    else fr.push_back(field_byte());
    if (cut_short) keep = $urandom_range(1, fr.size() - 1);
    else keep = fr.size();
    for (int i = 0; i < keep; i++) send_byte(fr[i]);
  endtask

  // stop sending and let every outstanding word drain
  task automatic quiesce();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input byte_t val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned budget;
    int unsigned r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 23; i++) send_byte(opening[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        quiesce();
        case (p)
          1: begin
            smk = 8'h00;
            emk = 8'hFF;
          end
          2: begin
            smk = 8'hFF;
            emk = 8'h00;
          end
          3: begin
            // equal markers: the closing byte restarts framing
            smk = 8'h7E;
            emk = 8'h7E;
          end
          default: begin
            smk = byte_t'($urandom_range(0, 255));
            emk = byte_t'($urandom_range(0, 255));
          end
        endcase
        write_reg(REG_START_MARKER, smk);
        write_reg(REG_END_MARKER, emk);
      end
      budget = sent + PHASE_BYTES;
      while (sent < budget) begin
        r = $urandom_range(0, 99);
        if (r < 75) send_frame(1'b0);
        else if (r < 88) send_frame(1'b1);
        else repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom_range(0, 255)));
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && words_due == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/fpp_pkg.sv
rtl/fpp_parser.sv
rtl/fpp_out_buf.sv
rtl/framed_packet_parser.sv
test/framed_packet_parser_checker.sv
test/framed_packet_parser_tb.sv
